// File: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: base64 stream decoder shared types
// Character classes, the front-to-back queue entry and the classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

   typedef logic [1:0] b64d_kind_type;

   localparam b64d_kind_type KIND_SKIP = 2'd0;
   localparam b64d_kind_type KIND_DATA = 2'd1;
   localparam b64d_kind_type KIND_PAD  = 2'd2;
   localparam b64d_kind_type KIND_BAD  = 2'd3;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      b64d_kind_type kind;
      logic [5:0]    sextet;
      logic          last;
   } b64d_entry_type;

   function automatic b64d_entry_type b64d_classify(input logic [7:0] c, input logic last);
      b64d_entry_type e;
      e.kind   = KIND_BAD;
      e.sextet = 6'd0;
      e.last   = last;
      priority if (c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
         e.kind = KIND_SKIP;
      end else if (c == CHAR_PAD) begin
         e.kind = KIND_PAD;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         e.kind   = KIND_DATA;
         e.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         e.kind   = KIND_DATA;
         e.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         e.kind   = KIND_DATA;
         e.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == CHAR_PLUS) begin
         e.kind   = KIND_DATA;
         e.sextet = 6'd62;
      end else if (c == CHAR_SLASH) begin
         e.kind   = KIND_DATA;
         e.sextet = 6'd63;
      end else begin
         e.kind = KIND_BAD;
      end
      return e;
   endfunction

endpackage

// File: hw/rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 text decoder
// One character in, one result out: an optional byte plus done and status.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   req     | req_valid / req_stall  | req_char_in, req_end_of_text
//   rsp     | rsp_valid / rsp_stall  | rsp_byte_valid, rsp_data_byte,
//           |                        | rsp_done_res, rsp_status
//
// One character per cycle sustained while rsp_stall is low; a character passes
// the queue and then the result register before its result is presented
// (classifier into queue, queue into the result register).
// Throughput is set by the one-entry-per-cycle decode stage while rsp_stall is low.
// Synchronous reset empties the queue and clears the decoder state.
// A stalled result holds the decode stage; the queue then fills and
// req_stall rises once QUEUE_DEPTH characters are waiting.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_done_res,
   output logic       rsp_status
);
   import b64d_pkg::*;

   b64d_entry_type push_entry;
   b64d_entry_type pop_entry;
   logic           push;
   logic           queue_full;
   logic           pop_valid;
   logic           pop;

   b64d_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (pop_valid),
      .in_entry       (pop_entry),
      .in_take        (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status)
   );

endmodule

// File: hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front: character classifier
// Accepts characters and turns each into a queue entry (class, sextet, last).
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_char_in,
   input  logic                     req_end_of_text,
   input  logic                     queue_full,
   output logic                     push,
   output b64d_pkg::b64d_entry_type push_entry
);
   import b64d_pkg::*;

   assign req_stall  = queue_full;
   assign push       = req_valid && !queue_full;
   assign push_entry = b64d_classify(req_char_in, req_end_of_text);

endmodule

// File: hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue: classified-character queue
// Short FIFO that decouples the classifier from the decode stage.
// ----------------------------------------------------------------------------
module b64d_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64d_pkg::b64d_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output b64d_pkg::b64d_entry_type pop_entry
);
   import b64d_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b64d_entry_type    mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back: sextet accumulator and result register
// Packs sextets into bytes, tracks stop and error, drives the result channel.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  b64d_pkg::b64d_entry_type in_entry,
   output logic                     in_take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_byte_valid,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_done_res,
   output logic                     rsp_status
);
   import b64d_pkg::*;

   logic [11:0] acc_ff, acc_in;
   logic [1:0]  phase_ff, phase_in;
   logic        stopped_ff, stopped_in;
   logic        bad_ff, bad_in;
   logic        out_valid_ff, out_valid_in;
   logic        byte_valid_ff, byte_valid_in;
   logic [7:0]  data_ff, data_in;
   logic        done_ff, done_in;
   logic        status_ff, status_in;
   logic [11:0] acc_next;

   // take a new entry whenever the result register is empty or draining
   assign in_take  = in_valid && (!out_valid_ff || !rsp_stall);
   assign acc_next = {acc_ff[5:0], in_entry.sextet};

   always_comb begin
      acc_in        = acc_ff;
      phase_in      = phase_ff;
      stopped_in    = stopped_ff;
      bad_in        = bad_ff;
      byte_valid_in = 1'b0;
      data_in       = 8'd0;
      done_in       = 1'b0;
      status_in     = 1'b0;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (in_take) begin
         out_valid_in = 1'b1;
         if (!stopped_ff) begin
            unique case (in_entry.kind)
               KIND_SKIP: ;
               KIND_PAD:  stopped_in = 1'b1;
               KIND_BAD: begin
                  stopped_in = 1'b1;
                  bad_in     = 1'b1;
               end
               KIND_DATA: begin
                  acc_in = acc_next;
                  unique case (phase_ff)
                     2'd0: phase_in = 2'd3;
                     2'd1: begin
                        byte_valid_in = 1'b1;
                        data_in       = acc_next[7:0];
                        phase_in      = 2'd0;
                     end
                     2'd2: begin
                        byte_valid_in = 1'b1;
                        data_in       = acc_next[9:2];
                        phase_in      = 2'd1;
                     end
                     2'd3: begin
                        byte_valid_in = 1'b1;
                        data_in       = acc_next[11:4];
                        phase_in      = 2'd2;
                     end
                     default: phase_in = phase_ff;
                  endcase
               end
               default: ;
            endcase
         end
         if (in_entry.last) begin
            done_in    = 1'b1;
            status_in  = bad_in;
            acc_in     = '0;
            phase_in   = '0;
            stopped_in = 1'b0;
            bad_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         phase_ff     <= '0;
         stopped_ff   <= 1'b0;
         bad_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         phase_ff     <= phase_in;
         stopped_ff   <= stopped_in;
         bad_ff       <= bad_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the payload while stalled
   always_ff @(posedge clock) begin
      if (in_take) begin
         byte_valid_ff <= byte_valid_in;
         data_ff       <= data_in;
         done_ff       <= done_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_status     = status_ff;

endmodule
